/* design/sih_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sih_pkg;
  localparam int MaxTypes = 128;
  localparam int MaxNameBytes = 64;
  localparam int NameWords = MaxNameBytes / 8;
  localparam int Slots = 2 * MaxTypes;
  localparam int IdW = $clog2(MaxTypes);
  localparam int CntW = $clog2(MaxTypes + 1);
  localparam int SlotW = $clog2(Slots);
  localparam int WordW = $clog2(NameWords);
  localparam int LenW = $clog2(MaxNameBytes + 1);
  localparam int SlotValW = $clog2(MaxTypes + 1);

  localparam logic [1:0] ReqCreate = 2'd0;
  localparam logic [1:0] ReqLookup = 2'd1;
  localparam logic [1:0] ReqName = 2'd2;
  localparam logic [1:0] ReqNone = 2'd3;

  localparam logic [1:0] StFound = 2'd0;
  localparam logic [1:0] StCreated = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StFull = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_MIX, S_MOD, S_PROBE, S_SLOTWAIT, S_CMPLEN, S_CMP,
    S_STORE, S_RESULT, S_NAMELEN, S_NAME
  } state_t;

  typedef enum logic [2:0] {
    M_NOT_ADD, M_XOR24, M_ADD38, M_XOR14, M_ADD24, M_XOR28, M_ADD31
  } mix_op_t;

  function automatic logic [63:0] mix_step(input mix_op_t op, input logic [63:0] h);
    logic [63:0] r;
    r = h;
    case (op)
      M_NOT_ADD: r = (~h) + (h << 21);
      M_XOR24: r = h ^ (h >> 24);
      M_ADD38: r = h + (h << 3) + (h << 8);
      M_XOR14: r = h ^ (h >> 14);
      M_ADD24: r = h + (h << 2) + (h << 4);
      M_XOR28: r = h ^ (h >> 28);
      M_ADD31: r = h + (h << 31);
      default: r = h;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

/* design/sih_modunit.sv */
`timescale 1ns / 1ps
`default_nettype none
module sih_modunit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [63:0] dividend,
  input  wire logic [sih_pkg::SlotW:0] divisor,
  output logic busy,
  output logic [sih_pkg::SlotW-1:0] remainder
);
  // restoring remainder, one dividend bit a cycle
  logic [63:0] dv;
  logic [sih_pkg::SlotW+1:0] rem;
  logic [6:0] cnt;
  logic [sih_pkg::SlotW+1:0] sh;

  assign sh = {rem[sih_pkg::SlotW:0], dv[63]};
  assign remainder = rem[sih_pkg::SlotW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 7'd64;
      dv <= dividend;
      rem <= '0;
    end else if (busy) begin
      dv <= dv << 1;
      if (sh >= {1'b0, divisor}) rem <= sh - {1'b0, divisor};
      else rem <= sh;
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

/* design/string_intern_hash_table_unit.sv */
// String interning table. A key arrives one 64-bit word per cycle (ready stays
// high for non-final words while the output is not stalled). On the final word
// the block runs a sequencer: a hash mix of shift-add and xor-shift steps, a
// bitwise remainder by the slot count, then per probe a slot read, a length
// check and up to 8 word compares, one name memory port; a new name is then
// stored word by word, and the result is registered once the output is free.
// After reset a clearing pass empties all 256 slots of the slot table before
// the first item is taken. Name reads give one result per stored word (a single
// result for an unknown id) after a setup state, then one word a cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none
module string_intern_hash_table_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] req_type,
  input  wire logic [63:0] key_word,
  input  wire logic [3:0] key_bytes,
  input  wire logic key_last,
  input  wire logic [6:0] type_id,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [1:0] status,
  output logic [6:0] result_id,
  output logic [7:0] id_count,
  output logic [63:0] name_word,
  output logic [3:0] name_bytes,
  output logic result_last
);
  localparam int SW = sih_pkg::SlotW;
  localparam int IW = sih_pkg::IdW;
  localparam int WW = sih_pkg::WordW;
  localparam int LW = sih_pkg::LenW;

  sih_pkg::state_t state, state_next;
  logic [7:0] active_reg;
  logic [IW:0] act;
  logic [SW:0] nslots;

  logic [sih_pkg::SlotValW-1:0] slot_mem [sih_pkg::Slots];
  logic [63:0] name_mem [sih_pkg::MaxTypes * sih_pkg::NameWords];
  logic [LW-1:0] len_mem [sih_pkg::MaxTypes];
  logic [63:0] key_buf [sih_pkg::NameWords];

  logic [LW-1:0] key_len;
  logic [sih_pkg::CntW-1:0] id_counter;
  logic [63:0] hash;
  logic [2:0] mix_cnt;
  logic [1:0] req;
  logic [SW-1:0] idx;
  logic [SW:0] probes;
  logic [sih_pkg::SlotValW-1:0] slot_rd;
  logic [63:0] name_rd;
  logic [LW-1:0] len_rd;
  logic [WW:0] wcnt;
  logic [IW-1:0] cur_id;
  logic [WW:0] nwords;
  logic mod_start, mod_busy;
  logic [SW-1:0] mod_rem;
  logic [SW:0] clr_cnt;

  logic out_v;
  logic [1:0] o_status;
  logic [IW-1:0] o_id;
  logic [63:0] o_word;
  logic [3:0] o_bytes;
  logic o_last;

  logic accept, out_free;
  logic [63:0] xsum;

  assign act = (active_reg == 8'd0) ? (IW+1)'(1) :
               (active_reg > 8'(sih_pkg::MaxTypes)) ? (IW+1)'(sih_pkg::MaxTypes) :
               active_reg[IW:0];
  assign nslots = {act, 1'b0};
  assign accept = in_valid && in_ready;
  assign out_free = !out_v || out_ready;

  always_comb begin
    xsum = '0;
    for (int i = 0; i < sih_pkg::NameWords; i++) xsum = xsum ^ key_buf[i];
  end

  sih_modunit u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .dividend(hash), .divisor(nslots),
    .busy(mod_busy), .remainder(mod_rem)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      sih_pkg::S_CLEAR: if (clr_cnt == (SW+1)'(sih_pkg::Slots - 1)) state_next = sih_pkg::S_IDLE;
      sih_pkg::S_IDLE: begin
        if (accept) begin
          if (req_type == sih_pkg::ReqName) state_next = sih_pkg::S_NAMELEN;
          else if (req_type != sih_pkg::ReqNone && key_last) state_next = sih_pkg::S_MIX;
        end
      end
      sih_pkg::S_MIX: if (mix_cnt == 3'd7) state_next = sih_pkg::S_MOD;
      sih_pkg::S_MOD: if (!mod_busy && !mod_start) state_next = sih_pkg::S_PROBE;
      sih_pkg::S_PROBE: state_next = sih_pkg::S_SLOTWAIT;
      sih_pkg::S_SLOTWAIT: begin
        if (probes == nslots) state_next = sih_pkg::S_RESULT;
        else if (slot_rd == '0) begin
          if (req == sih_pkg::ReqLookup || id_counter >= act) state_next = sih_pkg::S_RESULT;
          else state_next = sih_pkg::S_STORE;
        end else state_next = sih_pkg::S_CMPLEN;
      end
      sih_pkg::S_CMPLEN: begin
        if (len_rd != key_len) state_next = sih_pkg::S_PROBE;
        else state_next = sih_pkg::S_CMP;
      end
      sih_pkg::S_CMP: begin
        if (name_rd != key_buf[wcnt[WW-1:0]]) state_next = sih_pkg::S_PROBE;
        else if (wcnt == (WW+1)'(sih_pkg::NameWords - 1)) state_next = sih_pkg::S_RESULT;
      end
      sih_pkg::S_STORE:
        if (wcnt == (WW+1)'(sih_pkg::NameWords - 1)) state_next = sih_pkg::S_RESULT;
      sih_pkg::S_RESULT: if (out_free) state_next = sih_pkg::S_IDLE;
      sih_pkg::S_NAMELEN: if (wcnt == (WW+1)'(1)) state_next = sih_pkg::S_NAME;
      sih_pkg::S_NAME:
        if (out_free && (o_status == sih_pkg::StNotFound || wcnt + 1'b1 == nwords))
          state_next = sih_pkg::S_IDLE;
      default: state_next = sih_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == sih_pkg::S_IDLE) && out_free;
    mod_start = (state == sih_pkg::S_MIX) && (mix_cnt == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sih_pkg::S_CLEAR;
      active_reg <= 8'd128;
      id_counter <= '0;
      key_len <= '0;
      hash <= '0;
      out_v <= 1'b0;
      clr_cnt <= '0;
      mix_cnt <= '0;
      wcnt <= '0;
      for (int i = 0; i < sih_pkg::NameWords; i++) key_buf[i] <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) active_reg <= cfg_wdata;
      if (out_v && out_ready && state != sih_pkg::S_RESULT && state != sih_pkg::S_NAME)
        out_v <= 1'b0;
      unique case (state)
        sih_pkg::S_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        sih_pkg::S_IDLE: if (accept) begin
          req <= req_type;
          wcnt <= '0;
          mix_cnt <= '0;
          if (req_type == sih_pkg::ReqName) begin
            cur_id <= type_id[IW-1:0];
          end else if (req_type != sih_pkg::ReqNone) begin
            for (int b = 0; b < 8; b++) begin
              if (b < int'(key_bytes) && int'(key_len) + b < sih_pkg::MaxNameBytes)
                key_buf[(int'(key_len) + b) / 8][((int'(key_len) + b) % 8) * 8 +: 8] <=
                  key_buf[(int'(key_len) + b) / 8][((int'(key_len) + b) % 8) * 8 +: 8] |
                  key_word[b*8 +: 8];
            end
            if (int'(key_len) + ((key_bytes > 4'd8) ? 8 : int'(key_bytes)) >
                sih_pkg::MaxNameBytes)
              key_len <= LW'(sih_pkg::MaxNameBytes);
            else
              key_len <= key_len + LW'((key_bytes > 4'd8) ? 4'd8 : key_bytes);
            if (key_last) hash <= xsum;
          end
        end
        sih_pkg::S_MIX: begin
          if (mix_cnt == 3'd0) begin
            hash <= sih_pkg::mix_step(sih_pkg::M_NOT_ADD, xsum);
          end else if (mix_cnt != 3'd7) begin
            hash <= sih_pkg::mix_step(sih_pkg::mix_op_t'(mix_cnt), hash);
          end
          mix_cnt <= mix_cnt + 1'b1;
        end
        sih_pkg::S_MOD: begin
          idx <= mod_rem;
          probes <= '0;
        end
        sih_pkg::S_PROBE: begin
          slot_rd <= slot_mem[idx];
          wcnt <= '0;
        end
        sih_pkg::S_SLOTWAIT: begin
          if (slot_rd != '0 && probes != nslots) begin
            cur_id <= IW'(slot_rd - 1'b1);
            len_rd <= len_mem[IW'(slot_rd - 1'b1)];
            name_rd <= name_mem[{IW'(slot_rd - 1'b1), WW'(0)}];
            wcnt <= (WW+1)'(1);
          end
          if (probes == nslots) begin
            o_status <= (req == sih_pkg::ReqLookup) ? sih_pkg::StNotFound : sih_pkg::StFull;
          end else if (slot_rd == '0) begin
            if (req == sih_pkg::ReqLookup) o_status <= sih_pkg::StNotFound;
            else if (id_counter >= act) o_status <= sih_pkg::StFull;
            else begin
              cur_id <= id_counter[IW-1:0];
              o_status <= sih_pkg::StCreated;
              wcnt <= '0;
            end
          end
        end
        sih_pkg::S_CMPLEN: begin
          wcnt <= '0;
          if (len_rd != key_len) begin
            idx <= (idx == SW'(nslots - 1'b1)) ? '0 : idx + 1'b1;
            probes <= probes + 1'b1;
          end
        end
        sih_pkg::S_CMP: begin
          name_rd <= name_mem[{cur_id, WW'(wcnt + 1'b1)}];
          wcnt <= wcnt + 1'b1;
          if (name_rd != key_buf[wcnt[WW-1:0]]) begin
            idx <= (idx == SW'(nslots - 1'b1)) ? '0 : idx + 1'b1;
            probes <= probes + 1'b1;
          end else o_status <= sih_pkg::StFound;
        end
        sih_pkg::S_STORE: begin
          name_mem[{cur_id, wcnt[WW-1:0]}] <= key_buf[wcnt[WW-1:0]];
          wcnt <= wcnt + 1'b1;
          if (wcnt == '0) begin
            len_mem[cur_id] <= key_len;
            slot_mem[idx] <= sih_pkg::SlotValW'(cur_id) + 1'b1;
            id_counter <= id_counter + 1'b1;
          end
        end
        sih_pkg::S_RESULT: if (out_free) begin
          out_v <= 1'b1;
          o_id <= (o_status >= sih_pkg::StNotFound) ? '0 : cur_id;
          o_word <= '0;
          o_bytes <= '0;
          o_last <= 1'b1;
          for (int i = 0; i < sih_pkg::NameWords; i++) key_buf[i] <= '0;
          key_len <= '0;
        end
        sih_pkg::S_NAMELEN: begin
          len_rd <= len_mem[cur_id];
          name_rd <= name_mem[{cur_id, WW'(0)}];
          o_status <= (sih_pkg::CntW'(cur_id) >= id_counter) ? sih_pkg::StNotFound :
                      sih_pkg::StFound;
          if (wcnt == (WW+1)'(1)) begin
            nwords <= (len_rd == '0) ? (WW+1)'(1) : (WW+1)'((len_rd + LW'(7)) >> 3);
            wcnt <= '0;
          end else wcnt <= wcnt + 1'b1;
        end
        sih_pkg::S_NAME: if (out_free) begin
          out_v <= 1'b1;
          if (o_status == sih_pkg::StNotFound) begin
            o_id <= '0; o_word <= '0; o_bytes <= '0; o_last <= 1'b1;
          end else begin
            o_id <= cur_id;
            o_word <= name_rd;
            o_bytes <= ((len_rd >> 3) > LW'(wcnt)) ? 4'd8 :
                       ((len_rd >> 3) == LW'(wcnt)) ? {1'b0, len_rd[2:0]} : 4'd0;
            o_last <= (wcnt + 1'b1 == nwords);
            wcnt <= wcnt + 1'b1;
            name_rd <= name_mem[{cur_id, WW'(wcnt + 1'b1)}];
          end
        end
        default: ;
      endcase
      if (state == sih_pkg::S_CLEAR) slot_mem[clr_cnt[SW-1:0]] <= '0;
    end
  end

  assign out_valid = out_v;
  assign status = o_status;
  assign result_id = o_id;
  assign id_count = 8'(id_counter);
  assign name_word = o_word;
  assign name_bytes = o_bytes;
  assign result_last = o_last;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == sih_pkg::S_IDLE) else $error("ready outside idle");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    id_counter <= sih_pkg::CntW'(sih_pkg::MaxTypes)) else $error("id count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire
